@@ rtl/urldec_pkg.sv @@
// shared types, character codes and helpers for the url percent decoder
package urldec_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  // output queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } urldec_ent_t;

  // results caused by one input item, in order
  typedef struct packed {
    logic [1:0]  count;
    urldec_ent_t r0;
    urldec_ent_t r1;
  } urldec_res_t;

  // hex digit value, no checking: digits map to 0..9, others to lowercase - 'a' + 10
  function automatic logic [7:0] hex_nibble(input logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      return ch - 8'h30;
    end
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      c = ch + 8'h20;
    end
    return c - 8'h61 + HEX_ALPHA_BASE;
  endfunction

endpackage

@@ rtl/urldec_dec.sv @@
// escape state and per-byte decode logic
module urldec_dec
  import urldec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  in_data,
  output urldec_res_t res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t     escape_phase, escape_phase_next;
  logic [7:0] first_digit, first_digit_next;
  logic [7:0] hex_hi, hex_lo;

  assign hex_hi = hex_nibble(first_digit);
  assign hex_lo = hex_nibble(in_data);

  // decode against current escape state
  always_comb begin
    escape_phase_next = PH_IDLE;
    first_digit_next  = first_digit;
    res.count   = 2'd0;
    res.r0.data = CH_NUL;
    res.r0.eos  = 1'b0;
    res.r1.data = CH_NUL;
    res.r1.eos  = 1'b1;
    case (escape_phase)
      PH_PCT: begin
        if (in_data == CH_NUL) begin
          res.count  = 2'd1;
          res.r0.eos = 1'b1;
        end else begin
          first_digit_next  = in_data;
          escape_phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        if (in_data == CH_NUL) begin
          // percent plus one byte: as text, '+' to space, '%' dropped
          if (first_digit == CH_PLUS) begin
            res.count   = 2'd2;
            res.r0.data = CH_SPACE;
          end else if (first_digit != CH_PERCENT) begin
            res.count   = 2'd2;
            res.r0.data = first_digit;
          end else begin
            res.count  = 2'd1;
            res.r0.eos = 1'b1;
          end
        end else begin
          res.count   = 2'd1;
          res.r0.data = {hex_hi[3:0], 4'h0} | hex_lo;
        end
      end
      default: begin
        if (in_data == CH_NUL) begin
          res.count  = 2'd1;
          res.r0.eos = 1'b1;
        end else if (in_data == CH_PERCENT) begin
          escape_phase_next = PH_PCT;
        end else if (in_data == CH_PLUS) begin
          res.count   = 2'd1;
          res.r0.data = CH_SPACE;
        end else begin
          res.count   = 2'd1;
          res.r0.data = in_data;
        end
      end
    endcase
  end

  // state update on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= PH_IDLE;
      first_digit  <= CH_NUL;
    end else if (fire) begin
      escape_phase <= escape_phase_next;
      first_digit  <= first_digit_next;
    end
  end

endmodule

@@ rtl/urldec_fifo.sv @@
// small result queue taking up to two entries per cycle
module urldec_fifo
  import urldec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  urldec_res_t       res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output urldec_ent_t       head
);

  urldec_ent_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n    = push ? res.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign room      = (count <= QCNT_W'(QDEPTH - 2));
  assign count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push && res.count != 2'd0) begin
      mem[wr_ptr] <= res.r0;
    end
    if (push && res.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= res.r1;
    end
  end

endmodule

@@ rtl/url_percent_decoder_top.sv @@
// top level of the streaming url percent decoder
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_byte             | input
//  out     | out_valid, out_ready, out_byte,         | output
//          | end_of_string                           |
//
// one byte per cycle while the queue has room; each byte is registered, then queued.
// a byte gives zero, one or two results into a four-entry result queue; the input
// register moves on when the queue has room for two entries.
// synchronous reset clears escape state, input register and queue.
// output stall backs up through the queue into in_ready.
module url_percent_decoder_top
  import urldec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_string
);

  logic        in_q_valid;
  logic [7:0]  in_q;
  logic        room;
  logic        move;
  urldec_res_t res;
  urldec_ent_t head;

  assign move     = in_q_valid && room;
  assign in_ready = !in_q_valid || move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_byte;
    end
  end

  urldec_dec u_dec (
    .clk     (clk),
    .rst     (rst),
    .fire    (move),
    .in_data (in_q),
    .res     (res)
  );

  urldec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (move),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte      = head.data;
  assign end_of_string = head.eos;

endmodule
